### rtl/threshold_offload_scheduler_macros.svh
// Assertion helpers used by the checker file.
`ifndef THRESHOLD_OFFLOAD_SCHEDULER_MACROS_SVH
`define THRESHOLD_OFFLOAD_SCHEDULER_MACROS_SVH

// same-cycle implication
`define TSCH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tsch_pkg.sv
`default_nettype none
package tsch_pkg;

    localparam int MAX_PEERS_DEF = 16;

    localparam logic [14:0] CPU_LIMIT_RST = 15'd20480;
    localparam logic [14:0] MEM_LIMIT_RST = 15'd20480;
    localparam logic [14:0] Q_HUNDRED     = 15'd25600;
    localparam logic [15:0] LOAD_MAX      = 16'hFFFF;

    // operations
    localparam logic [1:0] OP_BEGIN    = 2'd0;
    localparam logic [1:0] OP_ADD_PEER = 2'd1;
    localparam logic [1:0] OP_TASK     = 2'd2;
    localparam logic [1:0] OP_FINISH   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TASK = 2'd0;
    localparam logic [1:0] KIND_SPAN = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    // decision reasons
    localparam logic [1:0] RSN_LOCAL    = 2'd0;
    localparam logic [1:0] RSN_OFFLOAD  = 2'd1;
    localparam logic [1:0] RSN_FALLBACK = 2'd2;

    // register indexes
    localparam logic CFG_CPU_LIMIT = 1'b0;
    localparam logic CFG_MEM_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  node_number;
        logic [15:0] load_percent;
        logic [39:0] memory_size;
        logic [39:0] memory_free;
        logic        peer_reachable;
        logic [15:0] job_number;
        logic [39:0] job_memory;
        logic [31:0] job_cost;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] placed_job;
        logic [7:0]  target_node;
        logic [1:0]  decision_reason;
        logic [47:0] makespan;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] load;
        logic [39:0] free;
        logic [47:0] work;
    } peer_entry_t;

    typedef struct packed {
        logic start;
    } step_ctl_t;

    typedef struct packed {
        logic        done;
        logic        mem_ok;
        logic [31:0] load_step;
    } step_stat_t;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add48 = s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/tsch_peer_store.sv
`default_nettype none
module tsch_peer_store #(
    parameter int DEPTH = tsch_pkg::MAX_PEERS_DEF
) (
    input  wire                                           clk,
    input  wire                                           we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire tsch_pkg::peer_entry_t                    wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output tsch_pkg::peer_entry_t                         rdata
);
    tsch_pkg::peer_entry_t mem [DEPTH];
    tsch_pkg::peer_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### rtl/tsch_step_unit.sv
`default_nettype none
// Shared iterative unit: memory-limit compare by shift-add (one bit a step)
// and the Q8.8 load step cost*32/125 by radix-4 restoring division.
module tsch_step_unit (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire tsch_pkg::step_ctl_t ctl,
    input  wire [31:0]              cost,
    input  wire [47:0]              used,
    input  wire [39:0]              total,
    input  wire [14:0]              lim,
    output tsch_pkg::step_stat_t    stat
);
    localparam int MUL_STEPS = 15;
    localparam int DIV_STEPS = 19;

    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [65:0] acc_reg;
    logic [37:0]        x_reg;
    logic [6:0]         rem_reg;
    logic [31:0]        q_reg;
    logic [14:0]        lim_reg;
    logic [14:0]        k_reg;
    logic               lim_nz_reg;
    logic               total_z_reg;
    logic [47:0]        used_reg;
    logic [39:0]        total_reg;

    logic [8:0]         t;
    logic [1:0]         dig;
    logic [8:0]         sub;
    logic signed [65:0] acc_next;

    always_comb
    begin
        t = {rem_reg, x_reg[37:36]};
        if (t >= 9'd375)
        begin
            dig = 2'd3;
            sub = 9'd375;
        end
        else if (t >= 9'd250)
        begin
            dig = 2'd2;
            sub = 9'd250;
        end
        else if (t >= 9'd125)
        begin
            dig = 2'd1;
            sub = 9'd125;
        end
        else
        begin
            dig = 2'd0;
            sub = 9'd0;
        end
        acc_next = (acc_reg <<< 1)
                 + (lim_reg[14] ? $signed({26'd0, total_reg}) : 66'sd0)
                 - (k_reg[14] ? $signed({18'd0, used_reg}) : 66'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg     <= '0;
            x_reg       <= {1'b0, cost, 5'd0};
            rem_reg     <= '0;
            q_reg       <= '0;
            lim_reg     <= lim;
            k_reg       <= tsch_pkg::Q_HUNDRED;
            lim_nz_reg  <= (lim != 15'd0);
            total_z_reg <= (total == 40'd0);
            used_reg    <= used;
            total_reg   <= total;
        end
        else if (busy_reg)
        begin
            x_reg   <= {x_reg[35:0], 2'b00};
            rem_reg <= 7'(t - sub);
            q_reg   <= {q_reg[29:0], dig};
            if (cnt_reg < 5'(MUL_STEPS))
            begin
                acc_reg <= acc_next;
                lim_reg <= {lim_reg[13:0], 1'b0};
                k_reg   <= {k_reg[13:0], 1'b0};
            end
        end
    end

    assign stat.done      = done_reg;
    assign stat.mem_ok    = total_z_reg ? lim_nz_reg : (acc_reg > 66'sd0);
    assign stat.load_step = q_reg;
endmodule
`default_nettype wire

### rtl/threshold_offload_scheduler.sv
`default_nettype none
// Threshold offload scheduler, least-loaded peer placement.
// Input channel in_valid/in_ready/in_data carries one beat per operation:
// begin (local snapshot, empties peer table), add peer, schedule task,
// finish. Output channel out_valid/out_ready/out_data carries at most one
// result beat per input: task decision, makespan report, or table full.
// Config: cfg_we/cfg_index/cfg_data write cpu_limit (0) and memory_limit (1).
// Flow per operation, from the accepting edge:
//   begin, add peer without result: stay idle, ready again next cycle.
//   add peer to a full table: through S_OUT to the output register.
//   task: the shared step unit runs a 15-step shift-add limit compare
//   overlapped with 19 radix-4 division digits, then S_CALC decides; a
//   local result goes through S_OUT. Otherwise a peer RAM scan (S_SCAN),
//   a commit state (S_POST) and the output load (S_OUT).
//   finish: the same scan for the max work, then S_POST and S_OUT.
// One item is in flight at a time; in_ready is high only when idle.
// A result sits in the output register until taken; the next item is
// accepted meanwhile, and its result waits if the register is still full.
// Reset clears thresholds to 80.0%, local state to zero and the table
// count; peer RAM contents are left as is.
module threshold_offload_scheduler #(
    parameter int MAX_PEERS = tsch_pkg::MAX_PEERS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire tsch_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output tsch_pkg::out_item_t  out_data,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire [14:0]           cfg_data
);
    localparam int CNT_W = $clog2(MAX_PEERS + 1);
    localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PEERS);

    typedef enum logic [2:0] {S_IDLE, S_CALC, S_SCAN, S_POST, S_OUT} state_t;

    state_t               state_reg;
    tsch_pkg::in_item_t   in_reg;
    logic [14:0]          cpu_limit_reg;
    logic [14:0]          mem_limit_reg;
    logic [7:0]           local_id_reg;
    logic [15:0]          local_load_reg;
    logic [39:0]          local_total_reg;
    logic [47:0]          local_used_reg;
    logic [47:0]          local_work_reg;
    logic [CNT_W-1:0]     peer_count_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 rv_reg;
    logic                 found_reg;
    tsch_pkg::peer_entry_t best_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     ri_reg;
    logic [47:0]          span_reg;
    tsch_pkg::out_item_t  res_reg;
    tsch_pkg::out_item_t  out_reg;
    logic                 out_valid_reg;

    tsch_pkg::step_ctl_t   step_ctl;
    tsch_pkg::step_stat_t  step_stat;
    tsch_pkg::peer_entry_t rd_entry;
    tsch_pkg::peer_entry_t wr_entry;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;

    logic        accept;
    logic        issuing;
    logic        free_ok;
    logic        local_ok;
    logic [31:0] local_sum;
    logic [15:0] local_load_new;
    logic [31:0] peer_sum;
    logic        fit;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign issuing  = (state_reg == S_SCAN) && (issue_reg < peer_count_reg);
    assign step_ctl.start = accept && (in_data.operation == tsch_pkg::OP_TASK);

    always_comb
    begin
        // local free memory floored at zero, against the task's need
        if (local_total_reg > local_used_reg[39:0] && local_used_reg[47:40] == 8'd0)
        begin
            free_ok = ({8'd0, local_total_reg} - local_used_reg) >= {8'd0, in_reg.job_memory};
        end
        else
        begin
            free_ok = (in_reg.job_memory == 40'd0);
        end
        local_ok  = ({1'b0, cpu_limit_reg} > local_load_reg) && step_stat.mem_ok && free_ok;
        local_sum = {16'd0, local_load_reg} + step_stat.load_step;
        local_load_new = (local_sum > {17'd0, tsch_pkg::Q_HUNDRED})
                       ? {1'b0, tsch_pkg::Q_HUNDRED} : local_sum[15:0];
        peer_sum  = {16'd0, best_reg.load} + step_stat.load_step;
        fit = rd_entry.free >= in_reg.job_memory;

        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        wr_entry.id   = best_reg.id;
        wr_entry.load = (peer_sum > {16'd0, tsch_pkg::LOAD_MAX}) ? tsch_pkg::LOAD_MAX
                      : peer_sum[15:0];
        wr_entry.free = best_reg.free - in_reg.job_memory;
        wr_entry.work = tsch_pkg::sat_add48(best_reg.work, {16'd0, in_reg.job_cost});
        if (accept && in_data.operation == tsch_pkg::OP_ADD_PEER)
        begin
            mem_we        = in_data.peer_reachable && (peer_count_reg < FULL_CNT);
            mem_waddr     = peer_count_reg[IDX_W-1:0];
            wr_entry.id   = in_data.node_number;
            wr_entry.load = in_data.load_percent;
            wr_entry.free = in_data.memory_free;
            wr_entry.work = '0;
        end
        else if (state_reg == S_POST)
        begin
            mem_we = (in_reg.operation == tsch_pkg::OP_TASK) && found_reg;
        end
    end

    tsch_step_unit u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (step_ctl),
        .cost  (in_data.job_cost),
        .used  (local_used_reg),
        .total (local_total_reg),
        .lim   (mem_limit_reg),
        .stat  (step_stat)
    );

    tsch_peer_store #(.DEPTH(MAX_PEERS)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_entry),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cpu_limit_reg   <= tsch_pkg::CPU_LIMIT_RST;
            mem_limit_reg   <= tsch_pkg::MEM_LIMIT_RST;
            local_id_reg    <= '0;
            local_load_reg  <= '0;
            local_total_reg <= '0;
            local_used_reg  <= '0;
            local_work_reg  <= '0;
            peer_count_reg  <= '0;
            issue_reg       <= '0;
            rv_reg          <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tsch_pkg::CFG_CPU_LIMIT)
                begin
                    cpu_limit_reg <= cfg_data;
                end
                else
                begin
                    mem_limit_reg <= cfg_data;
                end
            end
            // S_OUT reloads the output register itself
            if (out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_reg <= in_data;
                        case (in_data.operation)
                            tsch_pkg::OP_BEGIN:
                            begin
                                local_id_reg    <= in_data.node_number;
                                local_load_reg  <= in_data.load_percent;
                                local_total_reg <= in_data.memory_size;
                                local_used_reg  <= (in_data.memory_size > in_data.memory_free)
                                    ? {8'd0, in_data.memory_size - in_data.memory_free}
                                    : 48'd0;
                                local_work_reg  <= '0;
                                peer_count_reg  <= '0;
                            end
                            tsch_pkg::OP_ADD_PEER:
                            begin
                                if (in_data.peer_reachable)
                                begin
                                    if (peer_count_reg < FULL_CNT)
                                    begin
                                        peer_count_reg <= peer_count_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        res_reg.result_kind     <= tsch_pkg::KIND_FULL;
                                        res_reg.placed_job      <= '0;
                                        res_reg.target_node     <= in_data.node_number;
                                        res_reg.decision_reason <= tsch_pkg::RSN_LOCAL;
                                        res_reg.makespan        <= '0;
                                        state_reg <= S_OUT;
                                    end
                                end
                            end
                            tsch_pkg::OP_TASK:
                            begin
                                state_reg <= S_CALC;
                            end
                            default:
                            begin
                                // finish: max over local and loaded peers
                                span_reg  <= local_work_reg;
                                issue_reg <= '0;
                                rv_reg    <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                        endcase
                    end
                end

                S_CALC:
                begin
                    if (step_stat.done)
                    begin
                        res_reg.result_kind <= tsch_pkg::KIND_TASK;
                        res_reg.placed_job  <= in_reg.job_number;
                        res_reg.target_node <= local_id_reg;
                        res_reg.makespan    <= '0;
                        if (local_ok)
                        begin
                            res_reg.decision_reason <= tsch_pkg::RSN_LOCAL;
                            local_work_reg <= tsch_pkg::sat_add48(local_work_reg,
                                                                  {16'd0, in_reg.job_cost});
                            local_used_reg <= tsch_pkg::sat_add48(local_used_reg,
                                                                  {8'd0, in_reg.job_memory});
                            local_load_reg <= local_load_new;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            issue_reg <= '0;
                            rv_reg    <= 1'b0;
                            found_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    rv_reg <= issuing;
                    if (issuing)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                        ri_reg    <= issue_reg[IDX_W-1:0];
                    end
                    if (rv_reg)
                    begin
                        if (in_reg.operation == tsch_pkg::OP_TASK)
                        begin
                            // strict less keeps the first entry on ties
                            if (fit && (!found_reg || rd_entry.load < best_reg.load))
                            begin
                                found_reg    <= 1'b1;
                                best_reg     <= rd_entry;
                                best_idx_reg <= ri_reg;
                            end
                        end
                        else if (rd_entry.work > span_reg)
                        begin
                            span_reg <= rd_entry.work;
                        end
                    end
                    if (!issuing && !rv_reg)
                    begin
                        state_reg <= S_POST;
                    end
                end

                S_POST:
                begin
                    if (in_reg.operation == tsch_pkg::OP_TASK)
                    begin
                        if (found_reg)
                        begin
                            res_reg.decision_reason <= tsch_pkg::RSN_OFFLOAD;
                            res_reg.target_node     <= best_reg.id;
                        end
                        else
                        begin
                            res_reg.decision_reason <= tsch_pkg::RSN_FALLBACK;
                            local_work_reg <= tsch_pkg::sat_add48(local_work_reg,
                                                                  {16'd0, in_reg.job_cost});
                            local_used_reg <= tsch_pkg::sat_add48(local_used_reg,
                                                                  {8'd0, in_reg.job_memory});
                        end
                    end
                    else
                    begin
                        res_reg.result_kind     <= tsch_pkg::KIND_SPAN;
                        res_reg.placed_job      <= '0;
                        res_reg.target_node     <= '0;
                        res_reg.decision_reason <= tsch_pkg::RSN_LOCAL;
                        res_reg.makespan        <= span_reg;
                    end
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

### rtl/tsch_checker.sv
`default_nettype none
`include "threshold_offload_scheduler_macros.svh"
module tsch_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      in_valid,
    input wire                      in_ready,
    input wire tsch_pkg::in_item_t  in_data,
    input wire                      out_valid,
    input wire                      out_ready,
    input wire tsch_pkg::out_item_t out_data
);
    `TSCH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed under stall")
    `TSCH_ASSERT_NEXT(a_task_busy, in_valid && in_ready && in_data.operation == tsch_pkg::OP_TASK, !in_ready, "ready right after task beat")
    `TSCH_ASSERT_SAME(a_kind, out_valid, out_data.result_kind == tsch_pkg::KIND_TASK || out_data.result_kind == tsch_pkg::KIND_SPAN || out_data.result_kind == tsch_pkg::KIND_FULL, "bad result kind")
    `TSCH_ASSERT_SAME(a_non_task, out_valid && out_data.result_kind != tsch_pkg::KIND_TASK, out_data.placed_job == 16'd0 && out_data.decision_reason == tsch_pkg::RSN_LOCAL, "stray decision fields")
    `TSCH_ASSERT_SAME(a_task_span, out_valid && out_data.result_kind == tsch_pkg::KIND_TASK, out_data.makespan == 48'd0 && out_data.decision_reason != 2'd3, "bad task decision fields")
endmodule

bind threshold_offload_scheduler tsch_checker u_tsch_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

### tb/tb_threshold_offload_scheduler.sv
module tb_threshold_offload_scheduler;

    localparam int NPEERS = 16;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
    localparam int SETTLE = 80;  // settle margin beyond the task worst case

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    tsch_pkg::in_item_t in_data;
    logic out_valid;
    logic out_ready;
    tsch_pkg::out_item_t out_data;
    logic cfg_we;
    logic cfg_index;
    logic [14:0] cfg_data;

    threshold_offload_scheduler #(.MAX_PEERS(NPEERS)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // scheduler shadow state
    logic [14:0] cpu_thr, mem_thr;
    logic [7:0]  loc_id;
    logic [15:0] loc_load;
    logic [39:0] loc_total;
    logic [47:0] loc_used, loc_work;
    int          npeer;
    tsch_pkg::peer_entry_t peers [NPEERS];

    tsch_pkg::in_item_t  pending_beats[$];
    tsch_pkg::out_item_t expected_results[$];
    int  errors;
    bit  quiet;        // no idling in the last phase
    int  in_gap, out_gap;
    bit  in_ready_seen;

    function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? SAT48 : s[47:0];
    endfunction

    // Predict the result (if any) of one accepted input beat.
    task automatic schedule_predict(input tsch_pkg::in_item_t it);
        tsch_pkg::out_item_t r;
        logic [39:0] lfree;
        logic [31:0] stp;
        logic [63:0] nl;
        logic [47:0] span;
        bit cpu_ok, mem_ok, found;
        int best;
        r = '0;
        case (it.operation)
            tsch_pkg::OP_BEGIN: begin
                loc_id = it.node_number;
                loc_load = it.load_percent;
                loc_total = it.memory_size;
                loc_used = (it.memory_size > it.memory_free) ?
                           48'(it.memory_size - it.memory_free) : '0;
                loc_work = '0;
                npeer = 0;
            end
            tsch_pkg::OP_ADD_PEER: begin
                if (it.peer_reachable) begin
                    if (npeer >= NPEERS) begin
                        r.result_kind = tsch_pkg::KIND_FULL;
                        r.target_node = it.node_number;
                        expected_results.insert(expected_results.size(), r);
                    end else begin
                        peers[npeer] = '{it.node_number, it.load_percent,
                                         it.memory_free, 48'd0};
                        npeer++;
                    end
                end
            end
            tsch_pkg::OP_TASK: begin
                cpu_ok = loc_load < cpu_thr;
                lfree = ({8'd0, loc_total} > loc_used) ? 40'({8'd0, loc_total} - loc_used) : '0;
                stp = 32'((64'(it.job_cost) * 256) / 1000);
                if (loc_total == 0) mem_ok = mem_thr > 0;
                else mem_ok = (128'(25600) * loc_used) < (128'(mem_thr) * loc_total);
                r.result_kind = tsch_pkg::KIND_TASK;
                r.placed_job = it.job_number;
                if (cpu_ok && mem_ok && lfree >= it.job_memory) begin
                    r.decision_reason = tsch_pkg::RSN_LOCAL;
                    r.target_node = loc_id;
                    loc_work = sat_sum(loc_work, 48'(it.job_cost));
                    loc_used = sat_sum(loc_used, 48'(it.job_memory));
                    nl = 64'(loc_load) + stp;
                    loc_load = (nl > 25600) ? 16'd25600 : nl[15:0];
                end else begin
                    found = 0;
                    best = 0;
                    for (int i = 0; i < npeer; i++)
                        if (peers[i].free >= it.job_memory &&
                            (!found || peers[i].load < peers[best].load)) begin
                            found = 1;
                            best = i;
                        end
                    if (found) begin
                        r.decision_reason = tsch_pkg::RSN_OFFLOAD;
                        r.target_node = peers[best].id;
                        peers[best].work = sat_sum(peers[best].work, 48'(it.job_cost));
                        peers[best].free = peers[best].free - it.job_memory;
                        nl = 64'(peers[best].load) + stp;
                        peers[best].load = (nl > 65535) ? 16'hFFFF : nl[15:0];
                    end else begin
                        r.decision_reason = tsch_pkg::RSN_FALLBACK;
                        r.target_node = loc_id;
                        loc_work = sat_sum(loc_work, 48'(it.job_cost));
                        loc_used = sat_sum(loc_used, 48'(it.job_memory));
                    end
                end
                expected_results.insert(expected_results.size(), r);
            end
            default: begin
                span = loc_work;
                for (int i = 0; i < npeer; i++)
                    if (peers[i].work > span) span = peers[i].work;
                r.result_kind = tsch_pkg::KIND_SPAN;
                r.makespan = span;
                expected_results.insert(expected_results.size(), r);
            end
        endcase
    endtask

    function automatic logic [39:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // sizes skewed to hit both the tiny and the saturating ends
    function automatic logic [39:0] pick40();
        case ($urandom_range(0, 4))
            0: return 40'($urandom_range(0, 16));
            1: return 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 16));
            2: return 40'($urandom_range(0, 100000));
            default: return rand40();
        endcase
    endfunction

    function automatic tsch_pkg::in_item_t mk(input logic [1:0] op);
        tsch_pkg::in_item_t it;
        it = '0;
        it.operation = op;
        it.node_number = 8'($urandom);
        it.load_percent = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, 25600));
        it.memory_size = pick40();
        it.memory_free = pick40();
        it.peer_reachable = ($urandom_range(0, 7) != 0);
        it.job_number = 16'($urandom);
        it.job_memory = ($urandom_range(0, 1)) ? 40'($urandom_range(0, 4096)) : pick40();
        it.job_cost = ($urandom_range(0, 2) == 0) ? 32'($urandom) :
                      32'($urandom_range(0, 5000));
        return it;
    endfunction

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // driver: advance at the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
        end else begin
            if (in_valid && in_ready_seen) begin
                // beat taken at the last rising edge
                if (pending_beats.size() != 0 &&
                    (quiet || (in_gap == 0 && $urandom_range(0, 9) != 0))) begin
                    in_data <= pending_beats.pop_front();
                    in_valid <= 1;
                end else begin
                    in_valid <= 0;
                    if (!quiet && in_gap == 0) in_gap = $urandom_range(1, 12);
                end
            end else if (!in_valid) begin
                if (in_gap > 0 && !quiet) in_gap--;
                else if (pending_beats.size() != 0) begin
                    in_gap = 0;
                    in_data <= pending_beats.pop_front();
                    in_valid <= 1;
                end
            end
            if (quiet) out_ready <= 1;
            else if (out_gap > 0) begin
                out_gap--;
                out_ready <= 0;
            end else if ($urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 12);
                out_ready <= 0;
            end else out_ready <= 1;
        end
    end

    // monitor: sample at the rising edge
    always @(posedge clk) begin
        tsch_pkg::out_item_t ex;
        in_ready_seen = in_valid && in_ready && rst_n;
        if (in_ready_seen) schedule_predict(in_data);
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat kind=%0d", out_data.result_kind);
                errors++;
            end else begin
                ex = expected_results.pop_front();
                if (out_data.result_kind !== ex.result_kind) begin
                    $error("result_kind exp %0d got %0d", ex.result_kind, out_data.result_kind);
                    errors++;
                end
                if (out_data.placed_job !== ex.placed_job) begin
                    $error("placed_job exp %0d got %0d", ex.placed_job, out_data.placed_job);
                    errors++;
                end
                if (out_data.target_node !== ex.target_node) begin
                    $error("target_node exp %0d got %0d", ex.target_node, out_data.target_node);
                    errors++;
                end
                if (out_data.decision_reason !== ex.decision_reason) begin
                    $error("decision_reason exp %0d got %0d",
                           ex.decision_reason, out_data.decision_reason);
                    errors++;
                end
                if (out_data.makespan !== ex.makespan) begin
                    $error("makespan exp %0d got %0d", ex.makespan, out_data.makespan);
                    errors++;
                end
            end
        end
    end

    // wait for all beats out and results back, then let the block settle
    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [14:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == tsch_pkg::CFG_CPU_LIMIT) cpu_thr = val;
        else mem_thr = val;
    endtask

    // one run: begin, some peers, tasks with an occasional random operation, finish
    task automatic queue_run(input int ntasks, input int maxp);
        tsch_pkg::in_item_t it;
        it = mk(tsch_pkg::OP_BEGIN);
        pending_beats.insert(pending_beats.size(), it);
        repeat ($urandom_range(0, maxp))
            pending_beats.insert(pending_beats.size(), mk(tsch_pkg::OP_ADD_PEER));
        for (int k = 0; k < ntasks; k++) begin
            if ($urandom_range(0, 15) == 0)
                pending_beats.insert(pending_beats.size(), mk(2'($urandom_range(0, 3))));
            else pending_beats.insert(pending_beats.size(), mk(tsch_pkg::OP_TASK));
        end
        pending_beats.insert(pending_beats.size(), mk(tsch_pkg::OP_FINISH));
    endtask

    initial begin
        tsch_pkg::in_item_t it;
        logic [14:0] cpu_set [5] = '{15'd0, 15'd25600, 15'd20480, 15'h7FFF, 15'd12800};
        logic [14:0] mem_set [5] = '{15'd25600, 15'd0, 15'd20480, 15'd12800, 15'h7FFF};
        errors = 0;
        quiet = 0;
        in_gap = 0;
        out_gap = 0;
        in_ready_seen = 0;
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        cfg_we = 0;
        cfg_index = tsch_pkg::CFG_CPU_LIMIT;
        cfg_data = '0;
        cpu_thr = tsch_pkg::CPU_LIMIT_RST;
        mem_thr = tsch_pkg::MEM_LIMIT_RST;
        loc_id = 0; loc_load = 0; loc_total = 0; loc_used = 0; loc_work = 0;
        npeer = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: task and finish on reset state, full table, extremes
        it = mk(tsch_pkg::OP_TASK); it.job_memory = '0; it.job_cost = '1;
        pending_beats.insert(pending_beats.size(), it);
        pending_beats.insert(pending_beats.size(), mk(tsch_pkg::OP_FINISH));
        it = '0; it.operation = tsch_pkg::OP_BEGIN; it.node_number = 8'hFF;
        it.load_percent = 16'hFFFF;
        it.memory_size = 40'd100; it.memory_free = 40'hFF_FFFF_FFFF;  // free above total
        pending_beats.insert(pending_beats.size(), it);
        for (int k = 0; k < 17; k++) begin
            it = mk(tsch_pkg::OP_ADD_PEER);
            it.peer_reachable = 1;
            it.load_percent = (k == 3) ? 16'd0 : 16'hFFFF;
            it.memory_free = 40'hFF_FFFF_FFFF;
            pending_beats.insert(pending_beats.size(), it);
        end
        it = mk(tsch_pkg::OP_ADD_PEER); it.peer_reachable = 0;
        pending_beats.insert(pending_beats.size(), it);
        it = mk(tsch_pkg::OP_TASK); it.job_memory = 40'hFF_FFFF_FFFF; it.job_cost = '1;
        pending_beats.insert(pending_beats.size(), it);
        it.job_number = 16'hFFFF; pending_beats.insert(pending_beats.size(), it);
        pending_beats.insert(pending_beats.size(), mk(tsch_pkg::OP_FINISH));
        drain();

        // random phases over several threshold settings
        for (int ph = 0; ph < 5; ph++) begin
            write_limit(tsch_pkg::CFG_CPU_LIMIT, cpu_set[ph]);
            write_limit(tsch_pkg::CFG_MEM_LIMIT, mem_set[ph]);
            if (ph == 4) quiet = 1;
            for (int r = 0; r < 12; r++)
                queue_run($urandom_range(2, 30), (r == 0) ? 20 : 8);
            drain();
        end

        if (errors == 0)
            $display("tb_threshold_offload_scheduler: done, clean");
        else
            $display("tb_threshold_offload_scheduler: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_threshold_offload_scheduler: done, errors");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/tsch_pkg.sv
rtl/tsch_peer_store.sv
rtl/tsch_step_unit.sv
rtl/threshold_offload_scheduler.sv
rtl/tsch_checker.sv
tb/tb_threshold_offload_scheduler.sv
